[hdl/i2csm_pkg.sv]
`default_nettype none

package i2csm_pkg;

    // payload store geometry
    localparam int MSG_BYTES = 64;
    localparam int ADDR_W    = 6;
    localparam int LEN_W     = 7;

    // item function codes
    localparam logic [2:0] FUNC_EVENT    = 3'd0;
    localparam logic [2:0] FUNC_ARM_SYNC = 3'd1;
    localparam logic [2:0] FUNC_ARM_RCV  = 3'd2;
    localparam logic [2:0] FUNC_ARM_SND  = 3'd3;
    localparam logic [2:0] FUNC_LOAD     = 3'd4;

    // target core status codes
    localparam logic [7:0] ST_OWN_ADDR_W = 8'h60;
    localparam logic [7:0] ST_RX_ACK     = 8'h80;
    localparam logic [7:0] ST_RX_NACK    = 8'h88;
    localparam logic [7:0] ST_STOP       = 8'hA0;
    localparam logic [7:0] ST_OWN_ADDR_R = 8'hA8;
    localparam logic [7:0] ST_TX_ACK     = 8'hB8;
    localparam logic [7:0] ST_TX_NACK    = 8'hC0;
    localparam logic [7:0] ST_TX_LAST    = 8'hC8;

    // frame bytes
    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] PAD_BYTE  = 8'hFF;

    // protocol phases
    typedef enum logic [8:0] {
        PH_IDLE      = 9'b000000001,
        PH_SYNC_ADDR = 9'b000000010,
        PH_SYNC_TYPE = 9'b000000100,
        PH_RCV_ADDR  = 9'b000001000,
        PH_RCV_TYPE  = 9'b000010000,
        PH_RCV_DATA  = 9'b000100000,
        PH_SND_ADDR  = 9'b001000000,
        PH_SND_TYPE  = 9'b010000000,
        PH_SND_DATA  = 9'b100000000
    } phase_t;

    // numeric phase code reported on protocol_state
    function automatic logic [3:0] phase_code(input phase_t ph);
        logic [3:0] code;
        case (ph)
            PH_IDLE:      code = 4'd0;
            PH_SYNC_ADDR: code = 4'd1;
            PH_SYNC_TYPE: code = 4'd2;
            PH_RCV_ADDR:  code = 4'd3;
            PH_RCV_TYPE:  code = 4'd4;
            PH_RCV_DATA:  code = 4'd5;
            PH_SND_ADDR:  code = 4'd6;
            PH_SND_TYPE:  code = 4'd7;
            PH_SND_DATA:  code = 4'd8;
            default:      code = 4'd0;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

[hdl/i2csm_send_store.sv]
`default_nettype none

module i2csm_send_store (
    input  wire logic                           clk,
    input  wire logic                           wr_en,
    input  wire logic [i2csm_pkg::ADDR_W-1:0]   wr_addr,
    input  wire logic [7:0]                     wr_data,
    input  wire logic [i2csm_pkg::ADDR_W-1:0]   rd_addr,
    output logic      [7:0]                     rd_data
);

    logic [7:0] mem [i2csm_pkg::MSG_BYTES];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, new data forwarded on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data <= wr_data;
        end
        else
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/i2c_slave_message_fsm_top.sv]
`default_nettype none
// an accepted item moves from the input register into the result register
// throughput: one item per cycle, stalls only when the result register is held
// the send store prefetches the next payload byte every cycle from the
// phase and byte count that the item in flight leaves behind
// reset (rst_n low, async): idle phase, ack state off, length one, no items held;
// the send store and the ack_enable output register are not cleared

module i2c_slave_message_fsm_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  func,
    input  wire logic [7:0]  bus_status,
    input  wire logic [7:0]  bus_byte,
    input  wire logic [7:0]  msg_id,
    input  wire logic [6:0]  msg_length,
    input  wire logic [5:0]  load_index,
    input  wire logic [7:0]  load_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             accepted,
    output logic      [7:0]  tx_byte,
    output logic             tx_load,
    output logic             ack_enable,
    output logic             sync_pulse,
    output logic      [7:0]  rx_byte,
    output logic      [5:0]  rx_index,
    output logic             rx_valid,
    output logic             rx_complete,
    output logic      [3:0]  protocol_state
);

    // input register
    logic        in_v_reg;
    logic [2:0]  func_reg;
    logic [7:0]  status_reg;
    logic [7:0]  bbyte_reg;
    logic [7:0]  id_reg;
    logic [6:0]  len_reg;
    logic [5:0]  lidx_reg;
    logic [7:0]  lbyte_reg;

    // protocol state
    i2csm_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [i2csm_pkg::LEN_W-1:0] count_reg, count_next, count_eff;
    logic [7:0]                  armed_id_reg, armed_id_next;
    logic [i2csm_pkg::LEN_W-1:0] armed_len_reg, armed_len_next;
    logic                        ack_reg, ack_next;

    // result register
    logic        out_v_reg;
    logic        acc_reg, acc_next;
    logic [7:0]  tx_reg, tx_next;
    logic        txl_reg, txl_next;
    logic        sp_reg, sp_next;
    logic [7:0]  rxb_reg, rxb_next;
    logic [5:0]  rxi_reg, rxi_next;
    logic        rxv_reg, rxv_next;
    logic        rxc_reg, rxc_next;
    logic [3:0]  pstate_reg;

    // store access
    logic                           st_we;
    logic [i2csm_pkg::ADDR_W-1:0]   st_raddr;
    logic [7:0]                     st_rdata;

    logic                        fire;
    logic [i2csm_pkg::LEN_W-1:0] len_clamped;
    logic [i2csm_pkg::LEN_W-1:0] count_inc;
    logic                        may_arm;

    // handshake: process when the result slot is free or being drained
    assign fire     = in_v_reg && (!out_v_reg || out_ready);
    assign in_ready = !in_v_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg   <= func;
            status_reg <= bus_status;
            bbyte_reg  <= bus_byte;
            id_reg     <= msg_id;
            len_reg    <= msg_length;
            lidx_reg   <= load_index;
            lbyte_reg  <= load_byte;
        end
    end

    // length clamp to 1..MSG_BYTES
    always_comb
    begin
        if (len_reg == '0)
        begin
            len_clamped = i2csm_pkg::LEN_W'(1);
        end
        else if (len_reg > i2csm_pkg::LEN_W'(i2csm_pkg::MSG_BYTES))
        begin
            len_clamped = i2csm_pkg::LEN_W'(i2csm_pkg::MSG_BYTES);
        end
        else
        begin
            len_clamped = len_reg;
        end
    end

    assign count_inc = count_reg + i2csm_pkg::LEN_W'(1);
    assign may_arm   = phase_reg inside {i2csm_pkg::PH_IDLE, i2csm_pkg::PH_SYNC_ADDR,
                                         i2csm_pkg::PH_SND_ADDR, i2csm_pkg::PH_RCV_ADDR};

    // next state and result for the item in the input register
    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        armed_id_next  = armed_id_reg;
        armed_len_next = armed_len_reg;
        ack_next       = ack_reg;
        acc_next       = 1'b0;
        tx_next        = '0;
        txl_next       = 1'b0;
        sp_next        = 1'b0;
        rxb_next       = '0;
        rxi_next       = '0;
        rxv_next       = 1'b0;
        rxc_next       = 1'b0;
        st_we          = 1'b0;

        case (func_reg)
            i2csm_pkg::FUNC_ARM_SYNC, i2csm_pkg::FUNC_ARM_RCV, i2csm_pkg::FUNC_ARM_SND:
            begin
                if (may_arm)
                begin
                    acc_next = 1'b1;
                    ack_next = 1'b1;
                    if (func_reg == i2csm_pkg::FUNC_ARM_SYNC)
                    begin
                        phase_next = i2csm_pkg::PH_SYNC_ADDR;
                    end
                    else
                    begin
                        armed_id_next  = id_reg;
                        armed_len_next = len_clamped;
                        phase_next     = (func_reg == i2csm_pkg::FUNC_ARM_RCV) ?
                                         i2csm_pkg::PH_RCV_ADDR : i2csm_pkg::PH_SND_ADDR;
                    end
                end
            end
            i2csm_pkg::FUNC_LOAD:
            begin
                st_we = fire;
            end
            i2csm_pkg::FUNC_EVENT:
            begin
                case (phase_reg)
                    i2csm_pkg::PH_SYNC_ADDR:
                    begin
                        if (status_reg == i2csm_pkg::ST_OWN_ADDR_W)
                        begin
                            phase_next = i2csm_pkg::PH_SYNC_TYPE;
                        end
                    end
                    i2csm_pkg::PH_SYNC_TYPE:
                    begin
                        if (status_reg == i2csm_pkg::ST_RX_ACK &&
                            bbyte_reg == i2csm_pkg::SYNC_BYTE)
                        begin
                            sp_next    = 1'b1;
                            ack_next   = 1'b0;
                            phase_next = i2csm_pkg::PH_IDLE;
                        end
                        else
                        begin
                            phase_next = i2csm_pkg::PH_SYNC_ADDR;
                        end
                    end
                    i2csm_pkg::PH_RCV_ADDR:
                    begin
                        if (status_reg == i2csm_pkg::ST_OWN_ADDR_W)
                        begin
                            phase_next = i2csm_pkg::PH_RCV_TYPE;
                        end
                    end
                    i2csm_pkg::PH_RCV_TYPE:
                    begin
                        if (status_reg == i2csm_pkg::ST_STOP)
                        begin
                            phase_next = i2csm_pkg::PH_RCV_ADDR;
                        end
                        else if (status_reg == i2csm_pkg::ST_RX_ACK)
                        begin
                            if (bbyte_reg == armed_id_reg)
                            begin
                                count_next = '0;
                                phase_next = i2csm_pkg::PH_RCV_DATA;
                            end
                            else
                            begin
                                ack_next   = 1'b0;
                                phase_next = i2csm_pkg::PH_IDLE;
                            end
                        end
                    end
                    i2csm_pkg::PH_RCV_DATA:
                    begin
                        if (status_reg == i2csm_pkg::ST_STOP)
                        begin
                            phase_next = i2csm_pkg::PH_RCV_ADDR;
                        end
                        else if (status_reg == i2csm_pkg::ST_RX_ACK)
                        begin
                            rxb_next   = bbyte_reg;
                            rxi_next   = count_reg[5:0];
                            rxv_next   = 1'b1;
                            count_next = count_inc;
                            if (count_inc >= armed_len_reg)
                            begin
                                rxc_next   = 1'b1;
                                ack_next   = 1'b0;
                                phase_next = i2csm_pkg::PH_IDLE;
                            end
                        end
                        else if (status_reg == i2csm_pkg::ST_RX_NACK)
                        begin
                            phase_next = i2csm_pkg::PH_IDLE;
                        end
                    end
                    i2csm_pkg::PH_SND_ADDR:
                    begin
                        if (status_reg == i2csm_pkg::ST_OWN_ADDR_R)
                        begin
                            tx_next    = armed_id_reg;
                            txl_next   = 1'b1;
                            phase_next = i2csm_pkg::PH_SND_TYPE;
                        end
                    end
                    i2csm_pkg::PH_SND_TYPE:
                    begin
                        // prefetched byte is entry zero in this phase
                        if (status_reg == i2csm_pkg::ST_TX_ACK)
                        begin
                            tx_next    = st_rdata;
                            txl_next   = 1'b1;
                            count_next = i2csm_pkg::LEN_W'(1);
                            phase_next = i2csm_pkg::PH_SND_DATA;
                        end
                        else
                        begin
                            ack_next   = 1'b0;
                            phase_next = i2csm_pkg::PH_IDLE;
                        end
                    end
                    i2csm_pkg::PH_SND_DATA:
                    begin
                        if (status_reg == i2csm_pkg::ST_TX_ACK)
                        begin
                            txl_next = 1'b1;
                            if (count_reg >= armed_len_reg)
                            begin
                                // read past the end pads
                                tx_next    = i2csm_pkg::PAD_BYTE;
                                ack_next   = 1'b0;
                                phase_next = i2csm_pkg::PH_IDLE;
                            end
                            else
                            begin
                                tx_next    = st_rdata;
                                count_next = count_inc;
                            end
                        end
                        else if (status_reg == i2csm_pkg::ST_TX_NACK)
                        begin
                            ack_next   = 1'b0;
                            phase_next = i2csm_pkg::PH_IDLE;
                        end
                        else if (status_reg == i2csm_pkg::ST_TX_LAST)
                        begin
                            phase_next = i2csm_pkg::PH_IDLE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // state as it stands after this cycle, for the store prefetch address
    assign phase_eff = fire ? phase_next : phase_reg;
    assign count_eff = fire ? count_next : count_reg;
    assign st_raddr  = (phase_eff == i2csm_pkg::PH_SND_TYPE) ? '0 :
                       count_eff[i2csm_pkg::ADDR_W-1:0];

    i2csm_send_store u_store (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (lidx_reg),
        .wr_data (lbyte_reg),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    // protocol state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= i2csm_pkg::PH_IDLE;
            count_reg     <= '0;
            armed_id_reg  <= '0;
            armed_len_reg <= i2csm_pkg::LEN_W'(1);
            ack_reg       <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            armed_id_reg  <= armed_id_next;
            armed_len_reg <= armed_len_next;
            ack_reg       <= ack_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_v_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            acc_reg    <= acc_next;
            tx_reg     <= tx_next;
            txl_reg    <= txl_next;
            sp_reg     <= sp_next;
            rxb_reg    <= rxb_next;
            rxi_reg    <= rxi_next;
            rxv_reg    <= rxv_next;
            rxc_reg    <= rxc_next;
            pstate_reg <= i2csm_pkg::phase_code(phase_next);
        end
    end

    // ack enable follows the state held with this result
    logic ack_out_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ack_out_reg <= ack_next;
        end
    end

    assign out_valid      = out_v_reg;
    assign accepted       = acc_reg;
    assign tx_byte        = tx_reg;
    assign tx_load        = txl_reg;
    assign ack_enable     = ack_out_reg;
    assign sync_pulse     = sp_reg;
    assign rx_byte        = rxb_reg;
    assign rx_index       = rxi_reg;
    assign rx_valid       = rxv_reg;
    assign rx_complete    = rxc_reg;
    assign protocol_state = pstate_reg;

endmodule

`default_nettype wire
